FILE: design/nfc_pkg.sv
// ----------------------------------------------------------------------------
// nfc_pkg: shared types and constants of the nfc stream checker
// field widths, stream packing offsets, quick-check codes and fsm types
// ----------------------------------------------------------------------------
package nfc_pkg;

  // field widths
  localparam int CP_W      = 21;
  localparam int CLASS_W   = 8;
  localparam int QC_W      = 2;
  localparam int SLOT_W    = 10;
  localparam int ENTRY_W   = 64;

  // default composition table depth
  localparam int PAIR_DEPTH_DEF = 1024;

  // stream widths (tdata fields packed from bit 0 up, padded to whole bytes)
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;

  // input tdata field offsets
  localparam int IN_CP_LSB    = 0;
  localparam int IN_CCC_LSB   = IN_CP_LSB + CP_W;
  localparam int IN_TAIL_LSB  = IN_CCC_LSB + CLASS_W;
  localparam int IN_QC_LSB    = IN_TAIL_LSB + CLASS_W;
  localparam int IN_SLOT_LSB  = IN_QC_LSB + QC_W;
  localparam int IN_FIRST_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int IN_COMP_LSB  = IN_FIRST_LSB + CP_W;
  localparam int IN_VALID_BIT = IN_COMP_LSB + CP_W;

  // table entry layout
  localparam int ENT_VALID_BIT = 63;
  localparam int ENT_FIRST_LSB = 42;
  localparam int ENT_SECOND_LSB = 21;
  localparam int ENT_COMP_LSB  = 0;

  // quick-check codes (anything else counts as maybe)
  localparam logic [QC_W-1:0] QC_YES = 2'd0;
  localparam logic [QC_W-1:0] QC_NO  = 2'd1;

  // item kind carried in tuser
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_LOAD  = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH
  } state_t;

  typedef enum logic [1:0] {
    V_MORE,
    V_RESET,
    V_BREAK
  } verdict_t;

  // which rule started a table search
  typedef enum logic {
    SK_STARTER,
    SK_MARK
  } search_kind_t;

endpackage

FILE: design/unicode_nfc_stream_checker.sv
// ----------------------------------------------------------------------------
// unicode_nfc_stream_checker: nfc quick-check over a stream of code points
// tracks starter, sequence length, last class and error suppression, and
// searches a loaded table of primary-composite pairs for maybe characters
// ----------------------------------------------------------------------------
// usage
//   in_*  : one transaction per character; in_tuser selects check (0) or
//           table load (1). in_tdata carries the character's properties and,
//           for loads, the pair written to table entry pair_slot.
//   out_* : one transaction per input transaction, in order; out_tdata[0]
//           is still_normalized (always 1 for loads).
// operation
//   loads and most checks produce their result in the cycle after acceptance.
//   a maybe character that may compose with the current starter scans the
//   pair table one entry per cycle through the single read port of the
//   table ram, lowest entry first, stopping at the first match.
//   one item is worked on at a time; the next is taken once the result
//   register is free or being emptied in the same cycle.
// reset
//   rst_n low clears the tracking state. afterwards the table is cleared,
//   one entry per cycle, with in_tready low.
// stalls
//   a result held by out_tready low stays in the output register; the block
//   takes no further input until it is taken.
// ----------------------------------------------------------------------------
module unicode_nfc_stream_checker #(
  parameter int PAIR_DEPTH = nfc_pkg::PAIR_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // code_point[20:0], combining_class[28:21], tail_class[36:29],
  // quick_check[38:37], pair_slot[48:39], pair_first[69:49],
  // pair_composite[90:70], pair_valid[91], zero pad[95:92]
  input  logic [nfc_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic [nfc_pkg::IN_USER_W-1:0]  in_tuser,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // still_normalized[0], zero pad[7:1]
  output logic [nfc_pkg::OUT_DATA_W-1:0] out_tdata
);

  import nfc_pkg::*;

  localparam int AW = $clog2(PAIR_DEPTH);
  localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PAIR_DEPTH - 1);

  // unpacked input fields
  logic               in_mode;
  logic [CP_W-1:0]    in_cp;
  logic [CLASS_W-1:0] in_ccc;
  logic [CLASS_W-1:0] in_tail;
  logic [QC_W-1:0]    in_qc;
  logic [SLOT_W-1:0]  in_slot;
  logic [CP_W-1:0]    in_first;
  logic [CP_W-1:0]    in_comp;
  logic               in_pvalid;

  assign in_mode   = in_tuser[0];
  assign in_cp     = in_tdata[IN_CP_LSB +: CP_W];
  assign in_ccc    = in_tdata[IN_CCC_LSB +: CLASS_W];
  assign in_tail   = in_tdata[IN_TAIL_LSB +: CLASS_W];
  assign in_qc     = in_tdata[IN_QC_LSB +: QC_W];
  assign in_slot   = in_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_first  = in_tdata[IN_FIRST_LSB +: CP_W];
  assign in_comp   = in_tdata[IN_COMP_LSB +: CP_W];
  assign in_pvalid = in_tdata[IN_VALID_BIT];

  // sequencer
  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;          // clear / search address
  logic          issued_all_r, issued_all_nxt;
  logic          dv_r, dv_nxt;            // ram read data belongs to search
  logic          rd_last_r, rd_last_nxt;  // that read was the last entry

  // text tracking state
  logic [CP_W-1:0]    starter_r, starter_nxt;
  logic               present_r, present_nxt;
  logic [1:0]         len_r, len_nxt;     // saturates at two
  logic [CLASS_W-1:0] prev_r, prev_nxt;
  logic               suppress_r, suppress_nxt;

  // item held during a search
  logic [CP_W-1:0]    cp_r, cp_nxt;
  logic [CLASS_W-1:0] tail_r, tail_nxt;
  search_kind_t       kind_r, kind_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_bit_r, out_bit_nxt;

  // table ram
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  nfc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  // handshake
  logic in_accept;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_bit_r};

  // load slot decode; slots beyond the table are dropped
  logic [SW-1:0] slot_wide;
  logic          slot_ok;
  assign slot_wide = SW'(in_slot);
  assign slot_ok   = 32'(in_slot) < 32'(PAIR_DEPTH);

  // the shared compare: one stored entry against starter and held character
  logic entry_hit;
  assign entry_hit = ram_rdata[ENT_VALID_BIT] &&
                     (ram_rdata[ENT_FIRST_LSB +: CP_W] == starter_r) &&
                     (ram_rdata[ENT_SECOND_LSB +: CP_W] == cp_r);

  // classify a check item: immediate verdict or table search
  verdict_t     pre_v;
  logic         pre_st_en;
  logic         need_search;
  search_kind_t pre_kind;

  always_comb begin
    pre_v       = V_MORE;
    pre_st_en   = 1'b0;
    need_search = 1'b0;
    pre_kind    = SK_STARTER;
    if ((in_ccc != '0) && (in_ccc < prev_r)) begin
      // combining mark out of canonical order
      pre_v = V_BREAK;
    end else if (in_qc == QC_YES) begin
      pre_v = (in_ccc != '0) ? V_MORE : V_RESET;
    end else if (in_qc == QC_NO) begin
      // a starter that must not appear still becomes the current starter
      pre_st_en = (in_ccc == '0);
      pre_v     = V_BREAK;
    end else if (in_ccc == '0) begin
      // maybe starter: may compose with the starter right before it
      if (present_r && (len_r <= 2'd1) && !suppress_r) begin
        need_search = 1'b1;
        pre_kind    = SK_STARTER;
      end else begin
        pre_v = V_RESET;
      end
    end else if (suppress_r) begin
      pre_v = V_MORE;
    end else if (((in_ccc > prev_r) || (len_r == 2'd1)) && present_r) begin
      // maybe mark not blocked from the starter
      need_search = 1'b1;
      pre_kind    = SK_MARK;
    end else begin
      pre_v = V_MORE;
    end
  end

  // next state and updates
  logic            apply_go;
  verdict_t        apply_v;
  logic [CP_W-1:0] apply_cp;
  logic [CLASS_W-1:0] apply_tail;
  logic            st_en;
  logic [CP_W-1:0] st_val;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    issued_all_nxt = issued_all_r;
    dv_nxt         = 1'b0;
    rd_last_nxt    = rd_last_r;
    cp_nxt         = cp_r;
    tail_nxt       = tail_r;
    kind_nxt       = kind_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r;
    ram_wdata      = '0;
    apply_go       = 1'b0;
    apply_v        = V_MORE;
    apply_cp       = in_cp;
    apply_tail     = in_tail;
    st_en          = 1'b0;
    st_val         = in_cp;

    case (state_r)
      S_CLEAR: begin
        // zero every entry, which marks it unused
        ram_we = 1'b1;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_mode == MODE_LOAD) begin
            // entry layout is valid, first, second, composite
            ram_we    = slot_ok;
            ram_waddr = slot_wide[AW-1:0];
            ram_wdata = {in_pvalid, in_first, in_cp, in_comp};
          end else if (need_search) begin
            cp_nxt         = in_cp;
            tail_nxt       = in_tail;
            kind_nxt       = pre_kind;
            cnt_nxt        = '0;
            issued_all_nxt = 1'b0;
            state_nxt      = S_SEARCH;
          end else begin
            apply_go = 1'b1;
            apply_v  = pre_v;
            st_en    = pre_st_en;
          end
        end
      end
      S_SEARCH: begin
        // one read issued per cycle, compared in the next cycle
        if (!issued_all_r) begin
          dv_nxt      = 1'b1;
          rd_last_nxt = (cnt_r == LAST_ADDR);
          if (cnt_r == LAST_ADDR) begin
            issued_all_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
        if (dv_r && (entry_hit || rd_last_r)) begin
          apply_go   = 1'b1;
          apply_cp   = cp_r;
          apply_tail = tail_r;
          dv_nxt     = 1'b0;
          state_nxt  = S_IDLE;
          if (entry_hit) begin
            apply_v = V_BREAK;
            st_en   = (kind_r == SK_STARTER);
            st_val  = ram_rdata[ENT_COMP_LSB +: CP_W];
          end else begin
            apply_v = (kind_r == SK_STARTER) ? V_RESET : V_MORE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // apply a load or a verdict to the tracking state and the output register
  always_comb begin
    starter_nxt   = starter_r;
    present_nxt   = present_r;
    len_nxt       = len_r;
    prev_nxt      = prev_r;
    suppress_nxt  = suppress_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;

    if (in_accept && (in_mode == MODE_LOAD)) begin
      out_valid_nxt = 1'b1;
      out_bit_nxt   = 1'b1;
    end

    if (apply_go) begin
      out_valid_nxt = 1'b1;
      prev_nxt      = apply_tail;
      case (apply_v)
        V_RESET: begin
          // new starter opens a fresh sequence
          suppress_nxt = 1'b0;
          starter_nxt  = apply_cp;
          present_nxt  = 1'b1;
          len_nxt      = 2'd1;
          out_bit_nxt  = 1'b1;
        end
        V_BREAK: begin
          suppress_nxt = 1'b1;
          len_nxt      = (len_r == 2'd2) ? len_r : len_r + 2'd1;
          out_bit_nxt  = 1'b0;
          if (st_en) begin
            starter_nxt = st_val;
            present_nxt = 1'b1;
          end
        end
        default: begin
          len_nxt     = (len_r == 2'd2) ? len_r : len_r + 2'd1;
          out_bit_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      issued_all_r <= 1'b0;
      dv_r         <= 1'b0;
      rd_last_r    <= 1'b0;
      starter_r    <= '0;
      present_r    <= 1'b0;
      len_r        <= 2'd0;
      prev_r       <= '0;
      suppress_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      issued_all_r <= issued_all_nxt;
      dv_r         <= dv_nxt;
      rd_last_r    <= rd_last_nxt;
      starter_r    <= starter_nxt;
      present_r    <= present_nxt;
      len_r        <= len_nxt;
      prev_r       <= prev_nxt;
      suppress_r   <= suppress_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // held item and result bit
  always_ff @(posedge clk) begin
    cp_r      <= cp_nxt;
    tail_r    <= tail_nxt;
    kind_r    <= kind_nxt;
    out_bit_r <= out_bit_nxt;
  end

endmodule

FILE: design/nfc_ram.sv
// ----------------------------------------------------------------------------
// nfc_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module nfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/nfc_sva_checker.sv
// ----------------------------------------------------------------------------
// nfc_sva_checker: port-level assertions for the nfc stream checker
// watches both streams over time; bound to the top level below
// ----------------------------------------------------------------------------
module nfc_sva_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [nfc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [nfc_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [nfc_pkg::OUT_DATA_W-1:0] out_tdata
);

  import nfc_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  // reset empties the result register and starts the table clear
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block active right after reset");

  // a table load answers next cycle with still_normalized set
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser[0] == MODE_LOAD) |=> out_tvalid && out_tdata[0])
    else $error("load transaction did not answer normalized");

  // a quick-check no character breaks the text at once
  a_qc_no_breaks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser[0] == MODE_CHECK) &&
    (in_tdata[IN_QC_LSB +: QC_W] == QC_NO) |=> out_tvalid && !out_tdata[0])
    else $error("quick-check no character not reported as a break");

endmodule

bind unicode_nfc_stream_checker nfc_sva_checker u_nfc_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
